// ===== rtl/core/plc_pkg.sv =====
// Shared types and constants for the piecewise-linear tone curve unit.
package plc_pkg;

   localparam int PIX_W         = 8;
   localparam int MAX_POINTS    = 16;
   localparam int GROUP_COUNT   = 4;
   localparam int PTS_PER_GROUP = 4;
   localparam int CNT_W         = 5;
   localparam int IDX_W         = 4;
   localparam int CSR_ADDR_W    = 6;
   localparam int CSR_DATA_W    = 64;
   localparam int REG_IDX_W     = 3;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = 2;
   localparam int QCNT_W        = 3;
   localparam int DIV_STAGES    = 8;

   localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_GROUP_0     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_GROUP_1     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_GROUP_2     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_GROUP_3     = 3'd4;

   localparam logic [CNT_W-1:0]      COUNT_RESET  = 5'd2;
   localparam logic [CNT_W-1:0]      COUNT_MIN    = 5'd2;
   localparam logic [CNT_W-1:0]      COUNT_MAX    = 5'd16;
   localparam logic [CSR_DATA_W-1:0] GROUP0_RESET = 64'h0000_0000_00FF_FF00;

   typedef struct packed {
      logic [CNT_W-1:0]                        point_count;
      logic [GROUP_COUNT-1:0][CSR_DATA_W-1:0]  groups;
   } cfg_type;

   // classified item: result = y1 +/- (a * dy) / dx
   typedef struct packed {
      logic [PIX_W-1:0] y1;
      logic [PIX_W-1:0] a;
      logic [PIX_W-1:0] dy;
      logic             neg;
      logic [PIX_W-1:0] dx;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== rtl/core/plc_csr.sv =====
// Configuration register file with APB-style access.
module plc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [plc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [plc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [plc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output plc_pkg::cfg_type                   cfg
);

   logic [plc_pkg::CNT_W-1:0]      count_ff;
   logic [plc_pkg::CSR_DATA_W-1:0] group_ff [plc_pkg::GROUP_COUNT];
   logic [plc_pkg::REG_IDX_W-1:0]  idx;
   logic                           wr_en;

   assign idx        = csr_paddr[plc_pkg::CSR_ADDR_W-1:3];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= plc_pkg::COUNT_RESET;
         group_ff[0] <= plc_pkg::GROUP0_RESET;
         group_ff[1] <= '0;
         group_ff[2] <= '0;
         group_ff[3] <= '0;
      end else if (wr_en) begin
         unique case (idx)
            plc_pkg::REG_POINT_COUNT: count_ff    <= csr_pwdata[plc_pkg::CNT_W-1:0];
            plc_pkg::REG_GROUP_0:     group_ff[0] <= csr_pwdata;
            plc_pkg::REG_GROUP_1:     group_ff[1] <= csr_pwdata;
            plc_pkg::REG_GROUP_2:     group_ff[2] <= csr_pwdata;
            plc_pkg::REG_GROUP_3:     group_ff[3] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         plc_pkg::REG_POINT_COUNT:
            csr_prdata = {{(plc_pkg::CSR_DATA_W-plc_pkg::CNT_W){1'b0}}, count_ff};
         plc_pkg::REG_GROUP_0: csr_prdata = group_ff[0];
         plc_pkg::REG_GROUP_1: csr_prdata = group_ff[1];
         plc_pkg::REG_GROUP_2: csr_prdata = group_ff[2];
         plc_pkg::REG_GROUP_3: csr_prdata = group_ff[3];
         default:              csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.point_count = count_ff;
      for (int g = 0; g < plc_pkg::GROUP_COUNT; g++) begin
         cfg.groups[g] = group_ff[g];
      end
   end

endmodule

// ===== rtl/core/plc_front.sv =====
// Front end: takes pixels, finds the curve segment and classifies the item.
module plc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [plc_pkg::PIX_W-1:0]   req_tdata,
   input  plc_pkg::cfg_type            cfg,
   input  plc_pkg::queue_status_type   q_status,
   output logic                        item_valid,
   output plc_pkg::item_type           item
);

   logic                        valid_ff, valid_in;
   logic [plc_pkg::PIX_W-1:0]   pix_ff;
   logic [plc_pkg::PIX_W-1:0]   px [plc_pkg::MAX_POINTS];
   logic [plc_pkg::PIX_W-1:0]   py [plc_pkg::MAX_POINTS];
   logic [plc_pkg::CNT_W-1:0]   n_eff;
   logic [plc_pkg::CNT_W-1:0]   n_m1;
   logic [plc_pkg::IDX_W-1:0]   last;
   logic                        found;
   logic [plc_pkg::IDX_W-1:0]   seg;
   logic [plc_pkg::PIX_W-1:0]   x1, x2, y1, y2;
   logic                        push;

   assign push       = valid_ff & ~q_status.full;
   assign req_tready = ~valid_ff | ~q_status.full;
   assign item_valid = valid_ff;

   always_comb begin
      for (int k = 0; k < plc_pkg::MAX_POINTS; k++) begin
         px[k] = cfg.groups[k/plc_pkg::PTS_PER_GROUP][(k%plc_pkg::PTS_PER_GROUP)*16 +: 8];
         py[k] = cfg.groups[k/plc_pkg::PTS_PER_GROUP][(k%plc_pkg::PTS_PER_GROUP)*16+8 +: 8];
      end
   end

   always_comb begin
      priority if (cfg.point_count < plc_pkg::COUNT_MIN) n_eff = plc_pkg::COUNT_MIN;
      else if (cfg.point_count > plc_pkg::COUNT_MAX)     n_eff = plc_pkg::COUNT_MAX;
      else                                              n_eff = cfg.point_count;
      n_m1 = n_eff - 5'd1;
      last = n_m1[plc_pkg::IDX_W-1:0];
   end

   // first matching segment wins: scan downward so the lowest index is kept
   always_comb begin
      found = 1'b0;
      seg   = '0;
      for (int i = plc_pkg::MAX_POINTS - 2; i >= 0; i--) begin
         if ((i < 32'(n_m1)) && (pix_ff >= px[i]) && (pix_ff <= px[i+1])) begin
            found = 1'b1;
            seg   = plc_pkg::IDX_W'(i);
         end
      end
      x1 = px[seg];
      x2 = px[seg + 4'd1];
      y1 = py[seg];
      y2 = py[seg + 4'd1];
   end

   // flat outputs ride through the back end with a zero product and dx of one
   always_comb begin
      item.a   = '0;
      item.dy  = '0;
      item.neg = 1'b0;
      item.dx  = 8'd1;
      priority if (pix_ff <= px[0]) begin
         item.y1 = py[0];
      end else if (pix_ff >= px[last]) begin
         item.y1 = py[last];
      end else if (!found) begin
         item.y1 = '0;
      end else if (x1 == x2) begin
         item.y1 = y1;
      end else begin
         item.y1  = y1;
         item.a   = pix_ff - x1;
         item.dx  = x2 - x1;
         item.neg = y2 < y1;
         item.dy  = (y2 < y1) ? (y1 - y2) : (y2 - y1);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) valid_in = 1'b1;
      else if (push)                valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) pix_ff <= req_tdata;
   end

endmodule

// ===== rtl/core/plc_queue.sv =====
// Short queue of classified items between front and back end.
module plc_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  plc_pkg::item_type           push_item,
   input  logic                        pop,
   output plc_pkg::item_type           head_item,
   output plc_pkg::queue_status_type   status
);

   plc_pkg::item_type              mem_ff [plc_pkg::QUEUE_DEPTH];
   logic [plc_pkg::QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [plc_pkg::QCNT_W-1:0]     count_ff;

   assign status.full  = count_ff == plc_pkg::QCNT_W'(plc_pkg::QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign head_item    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_item;
   end

endmodule

// ===== rtl/core/plc_back.sv =====
// Back end: multiply, bit-per-stage divide, and the output register.
module plc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  plc_pkg::item_type           in_item,
   output logic                        in_pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [plc_pkg::PIX_W-1:0]   rsp_tdata
);

   typedef struct packed {
      logic                        valid;
      logic [plc_pkg::PIX_W-1:0]   y1;
      logic                        neg;
      logic [plc_pkg::PIX_W-1:0]   dx;
      logic [plc_pkg::PIX_W-1:0]   rem;
      logic [plc_pkg::PIX_W-1:0]   low;
      logic [plc_pkg::PIX_W-1:0]   quo;
   } div_stage_type;

   div_stage_type                 stage_ff [plc_pkg::DIV_STAGES+1];
   div_stage_type                 stage_in [plc_pkg::DIV_STAGES+1];
   logic [2*plc_pkg::PIX_W-1:0]   prod;
   logic                          adv;
   logic                          out_valid_ff;
   logic [plc_pkg::PIX_W-1:0]     out_data_ff;
   logic [plc_pkg::PIX_W:0]       sum;
   logic [plc_pkg::PIX_W-1:0]     res;

   function automatic div_stage_type div_step(input div_stage_type s);
      logic [plc_pkg::PIX_W:0] t;
      logic                    ge;
      div_stage_type           r;
      t       = {s.rem, s.low[plc_pkg::PIX_W-1]};
      ge      = t >= {1'b0, s.dx};
      r       = s;
      r.rem   = ge ? plc_pkg::PIX_W'(t - {1'b0, s.dx}) : t[plc_pkg::PIX_W-1:0];
      r.low   = {s.low[plc_pkg::PIX_W-2:0], 1'b0};
      r.quo   = {s.quo[plc_pkg::PIX_W-2:0], ge};
      return r;
   endfunction

   assign adv    = ~out_valid_ff | rsp_tready;
   assign in_pop = adv & in_valid;
   assign prod   = in_item.a * in_item.dy;

   // the product is below 256*dx, so the quotient fits in eight bits
   always_comb begin
      stage_in[0].valid = in_valid;
      stage_in[0].y1    = in_item.y1;
      stage_in[0].neg   = in_item.neg;
      stage_in[0].dx    = in_item.dx;
      stage_in[0].rem   = prod[2*plc_pkg::PIX_W-1:plc_pkg::PIX_W];
      stage_in[0].low   = prod[plc_pkg::PIX_W-1:0];
      stage_in[0].quo   = '0;
      for (int k = 1; k <= plc_pkg::DIV_STAGES; k++) begin
         stage_in[k] = div_step(stage_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= plc_pkg::DIV_STAGES; k++) stage_ff[k].valid <= 1'b0;
      end else if (adv) begin
         for (int k = 0; k <= plc_pkg::DIV_STAGES; k++) stage_ff[k] <= stage_in[k];
      end
   end

   always_comb begin
      if (stage_ff[plc_pkg::DIV_STAGES].neg)
         sum = {1'b0, stage_ff[plc_pkg::DIV_STAGES].y1} -
               {1'b0, stage_ff[plc_pkg::DIV_STAGES].quo};
      else
         sum = {1'b0, stage_ff[plc_pkg::DIV_STAGES].y1} +
               {1'b0, stage_ff[plc_pkg::DIV_STAGES].quo};
      priority if (stage_ff[plc_pkg::DIV_STAGES].neg && sum[plc_pkg::PIX_W]) res = '0;
      else if (sum[plc_pkg::PIX_W])                                         res = '1;
      else                                               res = sum[plc_pkg::PIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset)    out_valid_ff <= 1'b0;
      else if (adv) out_valid_ff <= stage_ff[plc_pkg::DIV_STAGES].valid;
   end

   always_ff @(posedge clock) begin
      if (adv) out_data_ff <= res;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== rtl/core/piecewise_linear_tone_curve_unit.sv =====
// Top level of the piecewise-linear tone curve unit.
//
//  channel  | ports             | payload
//  ---------+-------------------+-------------------------------
//  input    | req_t*            | tdata[7:0] pixel_in
//  result   | rsp_t*            | tdata[7:0] pixel_out
//  config   | csr_p*            | count @0x00, point groups 0..3 @0x08..0x20
//
// One pixel per clock sustained while rsp_tready stays high; path: front register,
// queue, multiply stage, eight one-bit divide stages, output register.
// Synchronous active-high reset restores the default two-point curve.
// A stalled result stalls the back end; the front keeps filling the
// four-entry queue and drops req_tready only once it is full.
module piecewise_linear_tone_curve_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] pixel_in
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,   // [7:0] pixel_out
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [plc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [plc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [plc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   plc_pkg::cfg_type            cfg;
   plc_pkg::queue_status_type   q_status;
   plc_pkg::item_type           front_item, head_item;
   logic                        front_valid;
   logic                        q_push, q_pop;

   assign q_push = front_valid & ~q_status.full;

   plc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   plc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg),
      .q_status   (q_status),
      .item_valid (front_valid),
      .item       (front_item)
   );

   plc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .head_item (head_item),
      .status    (q_status)
   );

   plc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (~q_status.empty),
      .in_item    (head_item),
      .in_pop     (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty at once");

   a_stall_holds_front: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (front_valid && q_status.full))
      else $error("input stalled without a waiting item");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty queue");

endmodule
